// ----- design/sti_pkg.sv -----
// Shared types and widths for the sphere-triangle test.
// Holds the request and result structs and the front-to-back record.
// Depends on nothing.
`default_nettype none

package sti_pkg;

  localparam int COORD_W    = 16;
  localparam int RAD_W      = 15;
  localparam int DIF_W      = COORD_W + 1;
  localparam int DOT_W      = 2 * DIF_W + 2;
  localparam int CRS_W      = 2 * DIF_W + 1;
  localparam int VW         = 2 * CRS_W;
  localparam int DEN_W      = VW + 2;
  localparam int NUM_W      = VW + DIF_W + 3;
  localparam int LO_W       = CRS_W;
  localparam int QB         = COORD_W + 1;
  localparam int QS_W       = QB + 2;
  localparam int DIV_ST     = QB + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef logic [2:0][COORD_W-1:0] cvec_t;
  typedef logic [2:0][DIF_W-1:0]   dvec_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] center_z;
    logic [COORD_W-1:0] vert_a_x;
    logic [COORD_W-1:0] vert_a_y;
    logic [COORD_W-1:0] vert_a_z;
    logic [COORD_W-1:0] vert_b_x;
    logic [COORD_W-1:0] vert_b_y;
    logic [COORD_W-1:0] vert_b_z;
    logic [COORD_W-1:0] vert_c_x;
    logic [COORD_W-1:0] vert_c_y;
    logic [COORD_W-1:0] vert_c_z;
  } sti_in_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] closest_x;
    logic [COORD_W-1:0] closest_y;
    logic [COORD_W-1:0] closest_z;
  } sti_out_t;

  typedef struct packed {
    logic  direct;
    cvec_t s;
    cvec_t p;
  } sti_sb_t;

  typedef struct packed {
    sti_sb_t          sb;
    logic [VW-1:0]    w1;
    logic [VW-1:0]    w2;
    dvec_t            d1;
    dvec_t            d2;
    logic [DEN_W-1:0] den;
  } sti_rec_t;

endpackage

`default_nettype wire

// ----- design/sti_front.sv -----
// Front pipeline: differences, dot and cross products, region classification.
// Emits one sti_pkg::sti_rec_t per request. Depends on sti_pkg.
`default_nettype none

module sti_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sti_pkg::sti_in_t  in_data_i,
  output logic              rec_valid_o,
  input  logic              rec_ready_i,
  output sti_pkg::sti_rec_t rec_o
);

  localparam int CW  = sti_pkg::COORD_W;
  localparam int DW  = sti_pkg::DIF_W;
  localparam int PW  = sti_pkg::DOT_W;
  localparam int XW  = sti_pkg::CRS_W;
  localparam int VW  = sti_pkg::VW;
  localparam int NW  = sti_pkg::DEN_W;
  localparam int NST = 5;

  typedef logic [2:0][XW-1:0] xvec_t;

  typedef struct packed {
    sti_pkg::cvec_t p;
    sti_pkg::cvec_t a;
    sti_pkg::cvec_t b;
    sti_pkg::cvec_t c;
    sti_pkg::dvec_t ab;
    sti_pkg::dvec_t ac;
    sti_pkg::dvec_t bc;
  } geo_t;

  typedef struct packed {
    logic signed [PW-1:0] snom;
    logic signed [PW-1:0] sdenom;
    logic signed [PW-1:0] tnom;
    logic signed [PW-1:0] tdenom;
    logic signed [PW-1:0] unom;
    logic signed [PW-1:0] udenom;
  } dots_t;

  function automatic sti_pkg::dvec_t vdiff(sti_pkg::cvec_t x, sti_pkg::cvec_t y);
    sti_pkg::dvec_t r;
    for (int i = 0; i < 3; i++) begin
      r[i] = DW'($signed(x[i])) - DW'($signed(y[i]));
    end
    return r;
  endfunction

  function automatic logic signed [PW-1:0] dot3(sti_pkg::dvec_t x, sti_pkg::dvec_t y);
    logic signed [2*DW-1:0] m0, m1, m2;
    m0 = $signed(x[0]) * $signed(y[0]);
    m1 = $signed(x[1]) * $signed(y[1]);
    m2 = $signed(x[2]) * $signed(y[2]);
    return PW'(m0) + PW'(m1) + PW'(m2);
  endfunction

  function automatic xvec_t cross3(sti_pkg::dvec_t x, sti_pkg::dvec_t y);
    logic signed [2*DW-1:0] m12, m21, m20, m02, m01, m10;
    xvec_t r;
    m12 = $signed(x[1]) * $signed(y[2]);
    m21 = $signed(x[2]) * $signed(y[1]);
    m20 = $signed(x[2]) * $signed(y[0]);
    m02 = $signed(x[0]) * $signed(y[2]);
    m01 = $signed(x[0]) * $signed(y[1]);
    m10 = $signed(x[1]) * $signed(y[0]);
    r[0] = XW'(m12) - XW'(m21);
    r[1] = XW'(m20) - XW'(m02);
    r[2] = XW'(m01) - XW'(m10);
    return r;
  endfunction

  function automatic logic signed [VW-1:0] tdot(xvec_t x, xvec_t y);
    logic signed [2*XW-1:0] m0, m1, m2;
    m0 = $signed(x[0]) * $signed(y[0]);
    m1 = $signed(x[1]) * $signed(y[1]);
    m2 = $signed(x[2]) * $signed(y[2]);
    return VW'(m0) + VW'(m1) + VW'(m2);
  endfunction

  function automatic logic le0(logic [PW-1:0] x);
    return x[PW-1] || (x == '0);
  endfunction

  function automatic logic vle0(logic [VW-1:0] x);
    return x[VW-1] || (x == '0);
  endfunction

  logic [NST-1:0] v_q;
  logic           en;

  sti_pkg::sti_in_t  in_q;
  geo_t              g1_d, g1_q, g2_q, g3_q;
  sti_pkg::dvec_t    pa1_q, pb1_q, pc1_q, pa1_d, pb1_d, pc1_d;
  dots_t             dt2_d, dt2_q, dt3_q;
  xvec_t             n2_q, t1_q, t2_q, t3_q;
  logic signed [VW-1:0] va3_q, vb3_q, vc3_q;
  sti_pkg::sti_rec_t rec_d, rec_q;
  logic [NW-1:0]     den_e;

  assign en          = !v_q[NST-1] || rec_ready_i;
  assign in_ready_o  = en;
  assign rec_valid_o = v_q[NST-1];
  assign rec_o       = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  always_comb begin
    g1_d.p[0] = in_q.center_x;
    g1_d.p[1] = in_q.center_y;
    g1_d.p[2] = in_q.center_z;
    g1_d.a[0] = in_q.vert_a_x;
    g1_d.a[1] = in_q.vert_a_y;
    g1_d.a[2] = in_q.vert_a_z;
    g1_d.b[0] = in_q.vert_b_x;
    g1_d.b[1] = in_q.vert_b_y;
    g1_d.b[2] = in_q.vert_b_z;
    g1_d.c[0] = in_q.vert_c_x;
    g1_d.c[1] = in_q.vert_c_y;
    g1_d.c[2] = in_q.vert_c_z;
    g1_d.ab   = vdiff(g1_d.b, g1_d.a);
    g1_d.ac   = vdiff(g1_d.c, g1_d.a);
    g1_d.bc   = vdiff(g1_d.c, g1_d.b);
    pa1_d     = vdiff(g1_d.p, g1_d.a);
    pb1_d     = vdiff(g1_d.p, g1_d.b);
    pc1_d     = vdiff(g1_d.p, g1_d.c);
  end

  always_comb begin
    dt2_d.snom   = dot3(pa1_q, g1_q.ab);
    dt2_d.sdenom = -dot3(pb1_q, g1_q.ab);
    dt2_d.tnom   = dot3(pa1_q, g1_q.ac);
    dt2_d.tdenom = -dot3(pc1_q, g1_q.ac);
    dt2_d.unom   = dot3(pb1_q, g1_q.bc);
    dt2_d.udenom = -dot3(pc1_q, g1_q.bc);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q  <= in_data_i;
      g1_q  <= g1_d;
      pa1_q <= pa1_d;
      pb1_q <= pb1_d;
      pc1_q <= pc1_d;
      g2_q  <= g1_q;
      dt2_q <= dt2_d;
      n2_q  <= cross3(g1_q.ab, g1_q.ac);
      t1_q  <= cross3(pa1_q, pb1_q);
      t2_q  <= cross3(pb1_q, pc1_q);
      t3_q  <= cross3(pc1_q, pa1_q);
      g3_q  <= g2_q;
      dt3_q <= dt2_q;
      vc3_q <= tdot(n2_q, t1_q);
      va3_q <= tdot(n2_q, t2_q);
      vb3_q <= tdot(n2_q, t3_q);
      rec_q <= rec_d;
    end
  end

  always_comb begin
    rec_d.sb.direct = 1'b1;
    rec_d.sb.s      = g3_q.a;
    rec_d.sb.p      = g3_q.p;
    rec_d.w1        = '0;
    rec_d.w2        = '0;
    rec_d.d1        = g3_q.ab;
    rec_d.d2        = g3_q.ac;
    den_e           = '0;
    priority if (le0(dt3_q.snom) && le0(dt3_q.tnom)) begin
      rec_d.sb.s = g3_q.a;
    end else if (le0(dt3_q.sdenom) && le0(dt3_q.unom)) begin
      rec_d.sb.s = g3_q.b;
    end else if (le0(dt3_q.tdenom) && le0(dt3_q.udenom)) begin
      rec_d.sb.s = g3_q.c;
    end else if (vle0(vc3_q) && !dt3_q.snom[PW-1] && !dt3_q.sdenom[PW-1]) begin
      den_e    = NW'(dt3_q.snom) + NW'(dt3_q.sdenom);
      rec_d.w1 = VW'(dt3_q.snom);
    end else if (vle0(va3_q) && !dt3_q.unom[PW-1] && !dt3_q.udenom[PW-1]) begin
      den_e      = NW'(dt3_q.unom) + NW'(dt3_q.udenom);
      rec_d.w1   = VW'(dt3_q.unom);
      rec_d.sb.s = g3_q.b;
      rec_d.d1   = g3_q.bc;
    end else if (vle0(vb3_q) && !dt3_q.tnom[PW-1] && !dt3_q.tdenom[PW-1]) begin
      den_e    = NW'(dt3_q.tnom) + NW'(dt3_q.tdenom);
      rec_d.w1 = VW'(dt3_q.tnom);
      rec_d.d1 = g3_q.ac;
    end else begin
      den_e    = NW'(va3_q) + NW'(vb3_q) + NW'(vc3_q);
      rec_d.w1 = vb3_q;
      rec_d.w2 = vc3_q;
    end
    rec_d.den = den_e;
    if (den_e != '0) begin
      rec_d.sb.direct = !(rec_d.w1 != '0 || rec_d.w2 != '0 || den_e != '0);
    end
  end

endmodule

`default_nettype wire

// ----- design/sti_fifo.sv -----
// Short request queue between the front and back pipelines.
// Register-based, first word fall-through. Depends on sti_pkg.
`default_nettype none

module sti_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sti_pkg::sti_rec_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sti_pkg::sti_rec_t out_data_o
);

  localparam int AW = sti_pkg::FIFO_AW;
  localparam int DP = sti_pkg::FIFO_DEPTH;

  sti_pkg::sti_rec_t mem_q [DP];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;
  logic              push, pop;

  assign in_ready_o  = cnt_q != (AW+1)'(DP);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/sti_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a clamp on the output.
// Magnitude in, signed clamped quotient out. Depends on sti_pkg.
`default_nettype none

module sti_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [sti_pkg::NUM_W-1:0]         num_i,
  input  logic [sti_pkg::DEN_W-1:0]         den_i,
  input  logic                              neg_i,
  output logic signed [sti_pkg::QS_W-1:0]   quot_o
);

  localparam int NW = sti_pkg::NUM_W;
  localparam int DW = sti_pkg::DEN_W;
  localparam int QB = sti_pkg::QB;
  localparam int NS = sti_pkg::DIV_ST;
  localparam int SW = sti_pkg::QS_W;

  logic [NW-1:0] rem_q [NS];
  logic [NW-1:0] rem_d [NS];
  logic [DW-1:0] den_q [NS];
  logic [QB-1:0] quo_q [NS];
  logic [QB-1:0] quo_d [NS];
  logic [NS-1:0] neg_q, ovf_q;
  logic [NW-1:0] dsh;
  logic [QB:0]   mag;

  always_comb begin
    dsh      = '0;
    rem_d[0] = num_i;
    quo_d[0] = '0;
    for (int j = 1; j < NS; j++) begin
      dsh = NW'(den_q[j-1]) << (QB - j);
      if (rem_q[j-1] >= dsh) begin
        rem_d[j] = rem_q[j-1] - dsh;
        quo_d[j] = quo_q[j-1] | (QB'(1) << (QB - j));
      end else begin
        rem_d[j] = rem_q[j-1];
        quo_d[j] = quo_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= num_i >= (NW'(den_i) << QB);
      for (int j = 1; j < NS; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= den_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign mag    = ovf_q[NS-1] ? ((QB+1)'(1) << QB) : {1'b0, quo_q[NS-1]};
  assign quot_o = neg_q[NS-1] ? -$signed(SW'(mag)) : $signed(SW'(mag));

endmodule

`default_nettype wire

// ----- design/sti_back.sv -----
// Back pipeline: numerators, division, point assembly with saturation, hit test.
// Uses three sti_div lanes. Depends on sti_pkg and sti_div.
`default_nettype none

module sti_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sti_pkg::RAD_W-1:0]   radius_i,
  input  logic                        rec_valid_i,
  output logic                        rec_ready_o,
  input  sti_pkg::sti_rec_t           rec_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sti_pkg::sti_out_t           out_data_o
);

  localparam int CW   = sti_pkg::COORD_W;
  localparam int DFW  = sti_pkg::DIF_W;
  localparam int VW   = sti_pkg::VW;
  localparam int LW   = sti_pkg::LO_W;
  localparam int NW   = sti_pkg::NUM_W;
  localparam int DNW  = sti_pkg::DEN_W;
  localparam int SW   = sti_pkg::QS_W;
  localparam int RW   = sti_pkg::RAD_W;
  localparam int PLW  = LW + 1 + DFW;
  localparam int PHW  = VW - LW + DFW;
  localparam int AW   = SW + 1;
  localparam int SQW  = 2 * DFW;
  localparam int DSW  = SQW + 2;
  localparam int NST  = 3 + sti_pkg::DIV_ST + 2;
  localparam int NSB  = NST - 2;

  logic [NST-1:0] v_q;
  logic           en;

  sti_pkg::sti_sb_t     sb_q [NSB];
  logic signed [PLW-1:0] pl1_q [3], pl2_q [3];
  logic signed [PHW-1:0] ph1_q [3], ph2_q [3];
  logic [DNW-1:0]        den1_q, den2_q;
  logic signed [NW-1:0]  num2_q [3];
  logic [NW-1:0]         nmag3_q [3];
  logic [DNW-1:0]        dmag3_q;
  logic                  neg3_q [3];
  logic signed [SW-1:0]  quot [3];
  logic signed [AW-1:0]  sum_d [3];
  logic [CW-1:0]         res_d [3];
  sti_pkg::cvec_t        res4_q;
  logic [DFW-1:0]        dd4_q [3];
  logic [SQW-1:0]        sq [3];
  logic [DSW-1:0]        sq_sum;
  logic [2*RW-1:0]       r2;
  sti_pkg::sti_out_t     out_q;
  sti_pkg::sti_sb_t      sb4;

  assign en          = !v_q[NST-1] || out_ready_i;
  assign rec_ready_o = en;
  assign out_valid_o = v_q[NST-1];
  assign out_data_o  = out_q;
  assign sb4         = sb_q[NSB-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], rec_valid_i};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    sti_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (nmag3_q[i]),
      .den_i  (dmag3_q),
      .neg_i  (neg3_q[i]),
      .quot_o (quot[i])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = AW'($signed(sb4.s[i])) + AW'(quot[i]);
      if (sb4.direct) begin
        res_d[i] = sb4.s[i];
      end else if (sum_d[i][AW-1:CW-1] == '0 || sum_d[i][AW-1:CW-1] == '1) begin
        res_d[i] = sum_d[i][CW-1:0];
      end else begin
        res_d[i] = {sum_d[i][AW-1], {(CW-1){!sum_d[i][AW-1]}}};
      end
    end
  end

  always_comb begin
    sq_sum = '0;
    for (int i = 0; i < 3; i++) begin
      sq[i]  = $signed(dd4_q[i]) * $signed(dd4_q[i]);
      sq_sum = sq_sum + DSW'(sq[i]);
    end
    r2 = radius_i * radius_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= rec_i.sb;
      for (int k = 1; k < NSB; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
      den1_q <= rec_i.den;
      den2_q <= den1_q;
      dmag3_q <= den2_q[DNW-1] ? -den2_q : den2_q;
      for (int i = 0; i < 3; i++) begin
        pl1_q[i]   <= $signed({1'b0, rec_i.w1[LW-1:0]}) * $signed(rec_i.d1[i]);
        ph1_q[i]   <= $signed(rec_i.w1[VW-1:LW]) * $signed(rec_i.d1[i]);
        pl2_q[i]   <= $signed({1'b0, rec_i.w2[LW-1:0]}) * $signed(rec_i.d2[i]);
        ph2_q[i]   <= $signed(rec_i.w2[VW-1:LW]) * $signed(rec_i.d2[i]);
        num2_q[i]  <= (NW'(ph1_q[i]) << LW) + NW'(pl1_q[i])
                    + (NW'(ph2_q[i]) << LW) + NW'(pl2_q[i]);
        nmag3_q[i] <= num2_q[i][NW-1] ? NW'(-num2_q[i]) : NW'(num2_q[i]);
        neg3_q[i]  <= num2_q[i][NW-1] ^ den2_q[DNW-1];
        res4_q[i]  <= res_d[i];
        dd4_q[i]   <= DFW'($signed(res_d[i])) - DFW'($signed(sb4.p[i]));
      end
      out_q.hit       <= sq_sum <= DSW'(r2);
      out_q.closest_x <= res4_q[0];
      out_q.closest_y <= res4_q[1];
      out_q.closest_z <= res4_q[2];
    end
  end

endmodule

`default_nettype wire

// ----- design/sphere_triangle_intersect.sv -----
// Sphere against triangle test: closest triangle point and hit flag.
// Top level: radius register, front pipeline, request queue, back pipeline.
// Depends on sti_pkg, sti_front, sti_fifo, sti_back.
// Throughput: one request per cycle with no output stall; dividers pipelined.
// Reset: asynchronous active low, clears all valid state and the radius to 0.
`default_nettype none

module sphere_triangle_intersect (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sti_pkg::sti_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sti_pkg::sti_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sti_pkg::RAD_W-1:0] cfg_data_i
);

  logic [sti_pkg::RAD_W-1:0] radius_q;
  logic                      f_valid, f_ready, b_valid, b_ready;
  sti_pkg::sti_rec_t         f_rec, b_rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  sti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .rec_valid_o (f_valid),
    .rec_ready_i (f_ready),
    .rec_o       (f_rec)
  );

  sti_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_rec),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_rec)
  );

  sti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (radius_q),
    .rec_valid_i (b_valid),
    .rec_ready_o (b_ready),
    .rec_i       (b_rec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- tb/sti_checker.sv -----
`timescale 1ns / 100ps
// Watches the request, result and radius channels of sphere_triangle_intersect.
// Predicts each result and compares it with what the block returns.
// Depends on sti_pkg.
module sti_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  sti_pkg::sti_in_t          in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  sti_pkg::sti_out_t         out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [sti_pkg::RAD_W-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef logic signed [127:0] wide_t;

  logic [sti_pkg::RAD_W-1:0] radius_q;
  sti_pkg::sti_out_t         closest_q[$];

  function automatic wide_t dot3(input wide_t u[3], input wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic void cross3(input wide_t u[3], input wide_t v[3], output wide_t r[3]);
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  function automatic sti_pkg::sti_out_t predict_closest(input sti_pkg::sti_in_t req,
                                                        input logic [sti_pkg::RAD_W-1:0] rad);
    wide_t p[3], a[3], b[3], c[3], q[3];
    wide_t ab[3], ac[3], bc[3], pa[3], pb[3], pc[3], amb[3], amc[3], bmc[3];
    wide_t ap[3], bp[3], cp[3], n[3], t[3];
    wide_t snom, sden, tnom, tden, unom, uden, va, vb, vc, den, dist2, r2, sat, d;
    sti_pkg::sti_out_t res;
    p[0] = $signed(req.center_x); p[1] = $signed(req.center_y); p[2] = $signed(req.center_z);
    a[0] = $signed(req.vert_a_x); a[1] = $signed(req.vert_a_y); a[2] = $signed(req.vert_a_z);
    b[0] = $signed(req.vert_b_x); b[1] = $signed(req.vert_b_y); b[2] = $signed(req.vert_b_z);
    c[0] = $signed(req.vert_c_x); c[1] = $signed(req.vert_c_y); c[2] = $signed(req.vert_c_z);
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i]; bc[i] = c[i] - b[i];
      pa[i] = p[i] - a[i]; pb[i] = p[i] - b[i]; pc[i] = p[i] - c[i];
      amb[i] = a[i] - b[i]; amc[i] = a[i] - c[i]; bmc[i] = b[i] - c[i];
      ap[i] = a[i] - p[i]; bp[i] = b[i] - p[i]; cp[i] = c[i] - p[i];
    end
    snom = dot3(pa, ab); sden = dot3(pb, amb);
    tnom = dot3(pa, ac); tden = dot3(pc, amc);
    unom = dot3(pb, bc); uden = dot3(pc, bmc);
    if (snom <= 0 && tnom <= 0) begin
      q = a;
    end else if (sden <= 0 && unom <= 0) begin
      q = b;
    end else if (tden <= 0 && uden <= 0) begin
      q = c;
    end else begin
      cross3(ab, ac, n);
      cross3(ap, bp, t); vc = dot3(n, t);
      cross3(bp, cp, t); va = dot3(n, t);
      cross3(cp, ap, t); vb = dot3(n, t);
      if (vc <= 0 && snom >= 0 && sden >= 0) begin
        den = snom + sden;
        for (int i = 0; i < 3; i++) q[i] = (den == 0) ? a[i] : a[i] + (snom * ab[i]) / den;
      end else if (va <= 0 && unom >= 0 && uden >= 0) begin
        den = unom + uden;
        for (int i = 0; i < 3; i++) q[i] = (den == 0) ? b[i] : b[i] + (unom * bc[i]) / den;
      end else if (vb <= 0 && tnom >= 0 && tden >= 0) begin
        den = tnom + tden;
        for (int i = 0; i < 3; i++) q[i] = (den == 0) ? a[i] : a[i] + (tnom * ac[i]) / den;
      end else begin
        den = va + vb + vc;
        for (int i = 0; i < 3; i++)
          q[i] = (den == 0) ? a[i] : a[i] + (vb * ab[i] + vc * ac[i]) / den;
      end
    end
    dist2 = 0;
    for (int i = 0; i < 3; i++) begin
      sat = q[i];
      if (sat < -32768) sat = -32768;
      if (sat > 32767) sat = 32767;
      q[i] = sat;
      d = sat - p[i];
      dist2 = dist2 + d * d;
    end
    r2 = rad;
    r2 = r2 * r2;
    res.hit       = (dist2 <= r2);
    res.closest_x = q[0][sti_pkg::COORD_W-1:0];
    res.closest_y = q[1][sti_pkg::COORD_W-1:0];
    res.closest_z = q[2][sti_pkg::COORD_W-1:0];
    return res;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("mismatch on %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
  endtask

  assign pending_o = closest_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sti_pkg::sti_out_t want;
    if (!rst_ni) begin
      radius_q <= '0;
      fail_count_o = 0;
      closest_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) radius_q <= cfg_data_i;
      if (in_valid_i && in_ready_i) closest_q.push_back(predict_closest(in_data_i, radius_q));
      if (out_valid_i && out_ready_i) begin
        if (closest_q.size() == 0) begin
          report_field("unexpected result", 0, 1);
        end else begin
          want = closest_q.pop_front();
          if (out_data_i.hit !== want.hit) report_field("hit", want.hit, out_data_i.hit);
          if (out_data_i.closest_x !== want.closest_x)
            report_field("closest_x", $signed(want.closest_x), $signed(out_data_i.closest_x));
          if (out_data_i.closest_y !== want.closest_y)
            report_field("closest_y", $signed(want.closest_y), $signed(out_data_i.closest_y));
          if (out_data_i.closest_z !== want.closest_z)
            report_field("closest_z", $signed(want.closest_z), $signed(out_data_i.closest_z));
        end
      end
    end
  end
endmodule

// ----- tb/sphere_triangle_intersect_tb.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for sphere_triangle_intersect: directed regions, then random triangles.
// Depends on sti_pkg, sphere_triangle_intersect and sti_checker.
module sphere_triangle_intersect_tb;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 40;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  sti_pkg::sti_in_t          in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  sti_pkg::sti_out_t         out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [sti_pkg::RAD_W-1:0] cfg_data = '0;
  int                        fail_count;
  int                        pending;
  int                        idle_cycles = 0;
  int                        burst_left = 0;
  int                        stall_mode = 0;
  int                        stall_cnt = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  sphere_triangle_intersect u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  sti_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver stalls: always ready, random, or a periodic pattern
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ((stall_cnt % 13) < 8);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic sti_pkg::sti_in_t make_tri(input int px, py, pz, ax, ay, az,
                                                input int bx, by, bz, cx, cy, cz);
    sti_pkg::sti_in_t r;
    r.center_x = px[15:0]; r.center_y = py[15:0]; r.center_z = pz[15:0];
    r.vert_a_x = ax[15:0]; r.vert_a_y = ay[15:0]; r.vert_a_z = az[15:0];
    r.vert_b_x = bx[15:0]; r.vert_b_y = by[15:0]; r.vert_b_z = bz[15:0];
    r.vert_c_x = cx[15:0]; r.vert_c_y = cy[15:0]; r.vert_c_z = cz[15:0];
    return r;
  endfunction

  function automatic int rand_coord(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic sti_pkg::sti_in_t rand_tri();
    int span;
    int sel;
    sti_pkg::sti_in_t r;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      span = (sel < 6) ? 1024 : ((sel < 9) ? 8192 : 8);
      r = make_tri(rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_coord(span), rand_coord(span), rand_coord(span),
                   rand_coord(span), rand_coord(span), rand_coord(span));
    end
    return r;
  endfunction

  task automatic send_request(input sti_pkg::sti_in_t req);
    logic rdy;
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  endtask

  task automatic write_radius(input logic [sti_pkg::RAD_W-1:0] rad);
    logic rdy;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= rad;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [sti_pkg::RAD_W-1:0] radii[6];
    radii = '{15'd0, 15'd32767, 15'd256, 15'd1000, 15'd0, 15'd1};
    radii[4] = $urandom_range(0, 32767);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_radius(15'd300);
    send_request(make_tri(-256, -256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(600, -10, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(-10, 600, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(128, -256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(300, 300, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(-256, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(64, 64, 256, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(0, -256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(300, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));
    send_request(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_tri(100, 100, 100, 0, 0, 0, 256, 0, 0, 512, 0, 0));
    send_request(make_tri(100, 100, 100, 50, 50, 0, 50, 50, 0, 300, 0, 0));
    send_request(make_tri(100, -100, 7, 0, 0, 0, 256, 0, 0, 256, 0, 0));
    send_request(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768, -32768, -32768));
    send_request(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 32767, 32767));
    send_request(make_tri(32767, 32767, 32767, -32768, -32768, -32768,
                          32767, -32768, -32768, -32768, 32767, -32768));
    send_request(make_tri(-32768, 32767, 0, 32767, -32768, 32767,
                          -32768, 32767, -32768, 32767, 32767, 32767));
    send_request(make_tri(0, 0, 0, 32767, -32768, 0, -32768, 32767, 0, 32767, 32767, 0));
    send_request(make_tri(0, 0, 100, -32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0));

    foreach (radii[k]) begin
      write_radius(radii[k]);
      repeat (275) send_request(rand_tri());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
design/sti_pkg.sv
design/sti_front.sv
design/sti_fifo.sv
design/sti_div.sv
design/sti_back.sv
design/sphere_triangle_intersect.sv
tb/sti_checker.sv
tb/sphere_triangle_intersect_tb.sv
